FILE: sv/tte_pkg.sv
// Shared types, constants and helper functions of the tab-to-space expander.
`default_nettype none

package tte_pkg;

  // Default geometry
  localparam int COLUMN_BITS_DEF = 16;
  localparam int MAX_TAB_DEF     = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths
  localparam int BYTE_BITS = 8;
  localparam int TW_BITS   = 7;
  localparam int OFF_BITS  = 6;

  // Tab width after reset
  localparam logic [TW_BITS-1:0] TAB_RESET = 7'd8;

  // Character codes
  localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_BITS-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_BITS-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;

  // One command from the front to the back: a byte and how often to emit it
  typedef struct packed {
    logic [BYTE_BITS-1:0] ch;
    logic [TW_BITS-1:0]   count;
  } cmd_t;

  // Clamp a written tab width into 1..max_tab
  function automatic logic [TW_BITS-1:0] eff_width(input logic [TW_BITS-1:0] tw,
                                                    input logic [TW_BITS-1:0] max_tab);
    logic [TW_BITS-1:0] w;
    w = tw;
    if (tw == '0) begin
      w = 7'd1;
    end else if (tw > max_tab) begin
      w = max_tab;
    end
    return w;
  endfunction

  // One restoring remainder step: shift in a bit, subtract the divisor if it fits
  function automatic logic [OFF_BITS-1:0] rem_step(input logic [OFF_BITS-1:0] rem,
                                                   input logic                bit_in,
                                                   input logic [TW_BITS-1:0]  divisor);
    logic [TW_BITS-1:0] partial;
    logic [TW_BITS-1:0] reduced;
    partial = {rem, bit_in};
    reduced = (partial >= divisor) ? (partial - divisor) : partial;
    return reduced[OFF_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/tab_to_space_expander.sv
// A pushed byte is written into the command queue, then loaded into the output stage
// registers that drive the result ports. One result per cycle while pop is held and
// commands wait: an ordinary byte gives one result, a tab one space per column up to
// the next stop (1..tab width), counted down by the output stage. A tab width write
// holds full high while the bit-serial remainder unit recomputes the tab-stop offsets.
// Reset (rst_ni low, asynchronous): tab width 8, column 0, queue and output empty.
`default_nettype none

module tab_to_space_expander #(
  parameter int COLUMN_BITS = tte_pkg::COLUMN_BITS_DEF,
  parameter int MAX_TAB     = tte_pkg::MAX_TAB_DEF,
  parameter int QUEUE_DEPTH = tte_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tte_pkg::TW_BITS-1:0]   cfg_wdata_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [tte_pkg::BYTE_BITS-1:0] in_byte_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [tte_pkg::BYTE_BITS-1:0]      out_byte_o,
  output logic                               last_o
);

  tte_pkg::cmd_t front_cmd;
  tte_pkg::cmd_t head_cmd;
  logic          front_push;
  logic          q_full, q_empty;
  logic          back_pop;

  // Classify bytes and track the column
  tte_front #(
    .COLUMN_BITS(COLUMN_BITS),
    .MAX_TAB    (MAX_TAB)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .in_byte_i  (in_byte_i),
    .full_o     (full),
    .cmd_o      (front_cmd),
    .cmd_push_o (front_push),
    .q_full_i   (q_full)
  );

  // Decouple front and back
  tte_queue #(
    .WIDTH($bits(tte_pkg::cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_cmd),
    .full_o (q_full),
    .pop_i  (back_pop),
    .data_o (head_cmd),
    .empty_o(q_empty)
  );

  // Expand commands into result transfers
  tte_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (head_cmd),
    .cmd_valid_i(~q_empty),
    .cmd_pop_o  (back_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

FILE: sv/tte_rem.sv
// Bit-serial remainder unit: column and column maximum modulo the tab width.
`default_nettype none

module tte_rem #(
  parameter int DIVIDEND_BITS = tte_pkg::COLUMN_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [tte_pkg::TW_BITS-1:0]  divisor_i,
  input  wire logic [DIVIDEND_BITS-1:0]     dividend_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [tte_pkg::OFF_BITS-1:0]      rem_col_o,
  output logic [tte_pkg::OFF_BITS-1:0]      rem_max_o
);

  localparam int CntBits = $clog2(DIVIDEND_BITS + 1);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [CntBits-1:0]               cnt_q, cnt_d;
  logic [DIVIDEND_BITS-1:0]         shift_q, shift_d;
  logic [tte_pkg::TW_BITS-1:0]      divisor_q, divisor_d;
  logic [tte_pkg::OFF_BITS-1:0]     rem_col_q, rem_col_d;
  logic [tte_pkg::OFF_BITS-1:0]     rem_max_q, rem_max_d;

  // Advance one dividend bit per cycle; the maximum column is all ones
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    divisor_d = divisor_q;
    rem_col_d = rem_col_q;
    rem_max_d = rem_max_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = CntBits'(DIVIDEND_BITS);
      shift_d   = dividend_i;
      divisor_d = divisor_i;
      rem_col_d = '0;
      rem_max_d = '0;
    end else if (busy_q) begin
      rem_col_d = tte_pkg::rem_step(rem_col_q, shift_q[DIVIDEND_BITS-1], divisor_q);
      rem_max_d = tte_pkg::rem_step(rem_max_q, 1'b1, divisor_q);
      shift_d   = shift_q << 1;
      cnt_d     = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    shift_q   <= shift_d;
    divisor_q <= divisor_d;
    rem_col_q <= rem_col_d;
    rem_max_q <= rem_max_d;
  end

  assign busy_o    = busy_q | done_q;
  assign done_o    = done_q;
  assign rem_col_o = rem_col_q;
  assign rem_max_o = rem_max_q;

endmodule

`default_nettype wire

FILE: sv/tte_front.sv
// Front end: accepts bytes, tracks column and tab-stop offset, issues commands.
`default_nettype none

module tte_front #(
  parameter int COLUMN_BITS = tte_pkg::COLUMN_BITS_DEF,
  parameter int MAX_TAB     = tte_pkg::MAX_TAB_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [tte_pkg::TW_BITS-1:0]   cfg_wdata_i,
  input  wire logic                          push_i,
  input  wire logic [tte_pkg::BYTE_BITS-1:0] in_byte_i,
  output logic                               full_o,
  output tte_pkg::cmd_t                      cmd_o,
  output logic                               cmd_push_o,
  input  wire logic                          q_full_i
);

  // Tab width in effect after reset, clamped to the widest stop
  localparam int ResetWidth = (MAX_TAB < int'(tte_pkg::TAB_RESET)) ? MAX_TAB
                                                                   : int'(tte_pkg::TAB_RESET);

  localparam logic [COLUMN_BITS-1:0]       ColMax      = '1;
  localparam logic [tte_pkg::TW_BITS-1:0]  MaxTab      = tte_pkg::TW_BITS'(MAX_TAB);
  localparam logic [tte_pkg::OFF_BITS-1:0] MaxModReset =
    tte_pkg::OFF_BITS'(ColMax % COLUMN_BITS'(ResetWidth));

  logic [tte_pkg::TW_BITS-1:0]  tab_width_q, tab_width_d;
  logic [COLUMN_BITS-1:0]       column_q, column_d;
  logic [tte_pkg::OFF_BITS-1:0] stop_off_q, stop_off_d;
  logic [tte_pkg::OFF_BITS-1:0] max_mod_q, max_mod_d;

  logic                         rem_busy, rem_done;
  logic [tte_pkg::OFF_BITS-1:0] rem_col, rem_max;

  logic [tte_pkg::TW_BITS-1:0]  tw;
  logic [tte_pkg::TW_BITS-1:0]  run_len;
  logic [COLUMN_BITS:0]         tab_sum;
  logic                         accept;
  logic                         is_tab;

  // Recompute the offsets after a tab width write
  tte_rem #(
    .DIVIDEND_BITS(COLUMN_BITS)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_we_i),
    .divisor_i (tte_pkg::eff_width(cfg_wdata_i, MaxTab)),
    .dividend_i(column_q),
    .busy_o    (rem_busy),
    .done_o    (rem_done),
    .rem_col_o (rem_col),
    .rem_max_o (rem_max)
  );

  // Hold input while the offsets are recomputed or the queue is full
  assign full_o = rem_busy | cfg_we_i | q_full_i;
  assign accept = push_i & ~full_o;

  assign tw      = tte_pkg::eff_width(tab_width_q, MaxTab);
  assign run_len = tw - {1'b0, stop_off_q};
  assign tab_sum = {1'b0, column_q} + (COLUMN_BITS + 1)'(run_len);
  assign is_tab  = (in_byte_i == tte_pkg::CH_TAB);

  // Build the command for the back end
  always_comb begin
    cmd_o.ch    = is_tab ? tte_pkg::CH_SPACE : in_byte_i;
    cmd_o.count = is_tab ? run_len : tte_pkg::TW_BITS'(1);
    cmd_push_o  = accept;
  end

  // Advance column and tab-stop offset
  always_comb begin
    tab_width_d = tab_width_q;
    column_d    = column_q;
    stop_off_d  = stop_off_q;
    max_mod_d   = max_mod_q;
    if (cfg_we_i) begin
      tab_width_d = cfg_wdata_i;
    end
    if (rem_done) begin
      stop_off_d = rem_col;
      max_mod_d  = rem_max;
    end
    if (accept) begin
      if (is_tab) begin
        if (tab_sum[COLUMN_BITS]) begin
          column_d   = ColMax;
          stop_off_d = max_mod_q;
        end else begin
          column_d   = tab_sum[COLUMN_BITS-1:0];
          stop_off_d = '0;
        end
      end else if (in_byte_i == tte_pkg::CH_NL || in_byte_i == tte_pkg::CH_CR) begin
        column_d   = '0;
        stop_off_d = '0;
      end else if (in_byte_i == tte_pkg::CH_BS) begin
        if (column_q != '0) begin
          column_d   = column_q - COLUMN_BITS'(1);
          stop_off_d = (stop_off_q == '0) ? tte_pkg::OFF_BITS'(tw - tte_pkg::TW_BITS'(1))
                                          : stop_off_q - tte_pkg::OFF_BITS'(1);
        end
      end else if (column_q != ColMax) begin
        column_d   = column_q + COLUMN_BITS'(1);
        stop_off_d = (({1'b0, stop_off_q} + tte_pkg::TW_BITS'(1)) >= tw) ? '0
                     : stop_off_q + tte_pkg::OFF_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_width_q <= tte_pkg::TAB_RESET;
      column_q    <= '0;
      stop_off_q  <= '0;
      max_mod_q   <= MaxModReset;
    end else begin
      tab_width_q <= tab_width_d;
      column_q    <= column_d;
      stop_off_q  <= stop_off_d;
      max_mod_q   <= max_mod_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tte_queue.sv
// Short register queue of commands between the front and back ends.
`default_nettype none

module tte_queue #(
  parameter int WIDTH = $bits(tte_pkg::cmd_t),
  parameter int DEPTH = tte_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);

  logic [WIDTH-1:0]   mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tte_back.sv
// Back end: emits each command's byte its count of times, marking the last.
`default_nettype none

module tte_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tte_pkg::cmd_t                 cmd_i,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_pop_o,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output logic [tte_pkg::BYTE_BITS-1:0]      out_byte_o,
  output logic                               last_o
);

  logic                              valid_q, valid_d;
  logic [tte_pkg::BYTE_BITS-1:0]     ch_q, ch_d;
  logic [tte_pkg::TW_BITS-1:0]       left_q, left_d;
  logic                              take, finish, load;

  assign take   = valid_q & pop_i;
  assign finish = take & (left_q == tte_pkg::TW_BITS'(1));
  assign load   = (~valid_q | finish) & cmd_valid_i;

  // Count down the run; fetch the next command as the last transfer goes
  always_comb begin
    valid_d = valid_q;
    ch_d    = ch_q;
    left_d  = left_q;
    if (load) begin
      valid_d = 1'b1;
      ch_d    = cmd_i.ch;
      left_d  = cmd_i.count;
    end else if (finish) begin
      valid_d = 1'b0;
    end else if (take) begin
      left_d = left_q - tte_pkg::TW_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
    end else begin
      valid_q <= valid_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
  end

  assign cmd_pop_o  = load;
  assign empty_o    = ~valid_q;
  assign out_byte_o = ch_q;
  assign last_o     = (left_q == tte_pkg::TW_BITS'(1));

endmodule

`default_nettype wire
